// ===== hdl/periodic_timer_bank_defines.svh =====
// assertion macros for the periodic timer bank
// included by the modules that carry concurrent checks
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

// check with the synchronous reset masking the property
`define PTB_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds while reset is high
`define PTB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ptb_pkg.sv =====
// shared types and constants for the periodic timer bank
// no dependencies
`timescale 1ns / 1ps

package ptb_pkg;

   // default sizing
   localparam int SLOT_COUNT_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;

   // results per poll and the counter that tracks them
   localparam int MAX_RESULTS = 16;
   localparam int RPT_CNT_W   = $clog2(MAX_RESULTS + 1);

   // port field widths
   localparam int OP_W      = 2;
   localparam int ID_W      = 4;
   localparam int FIELD_T_W = 32;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   // item operations
   typedef enum logic [OP_W-1:0] {
      OP_ARM  = 2'd0,
      OP_FREE = 2'd1,
      OP_POLL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // shared adder operation
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_CMP,
      ST_DIFF,
      ST_INC,
      ST_FIRE,
      ST_FLUSH
   } state_type;

   // write strobes into the slot store
   typedef struct packed {
      logic period_we;
      logic expiry_we;
   } store_we_type;

endpackage

// ===== hdl/ptb_alu.sv =====
// shared add / subtract unit of the timer bank
// depends on ptb_pkg
`timescale 1ns / 1ps

module ptb_alu #(
   parameter int TIME_BITS = ptb_pkg::TIME_BITS_DEF
) (
   input  ptb_pkg::alu_op_type   op,
   input  logic [TIME_BITS-1:0]  a,
   input  logic [TIME_BITS-1:0]  b,
   output logic [TIME_BITS-1:0]  y
);

   // modular sum or difference
   always_comb begin
      case (op)
         ptb_pkg::ALU_ADD: y = a + b;
         ptb_pkg::ALU_SUB: y = a - b;
         default:          y = a + b;
      endcase
   end

endmodule

// ===== hdl/ptb_store.sv =====
// period and expiry memories of the timer bank, registered read
// depends on ptb_pkg
`timescale 1ns / 1ps

module ptb_store #(
   parameter int SLOT_COUNT = ptb_pkg::SLOT_COUNT_DEF,
   parameter int TIME_BITS  = ptb_pkg::TIME_BITS_DEF,
   localparam int SW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                  clock,
   input  ptb_pkg::store_we_type we,
   input  logic [SW-1:0]         wr_addr,
   input  logic [TIME_BITS-1:0]  wr_period,
   input  logic [TIME_BITS-1:0]  wr_expiry,
   input  logic [SW-1:0]         rd_addr,
   output logic [TIME_BITS-1:0]  rd_period,
   output logic [TIME_BITS-1:0]  rd_expiry
);

   logic [TIME_BITS-1:0] period_mem [SLOT_COUNT];
   logic [TIME_BITS-1:0] expiry_mem [SLOT_COUNT];

   // write port
   always_ff @(posedge clock) begin
      if (we.period_we) begin
         period_mem[wr_addr] <= wr_period;
      end
      if (we.expiry_we) begin
         expiry_mem[wr_addr] <= wr_expiry;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_period <= period_mem[rd_addr];
      rd_expiry <= expiry_mem[rd_addr];
   end

endmodule

// ===== hdl/periodic_timer_bank.sv =====
// Arm, free and no-op items are taken in the idle state. A poll visits the slots in turn:
// an inactive slot takes only the store read, an active slot passes store read, sum,
// compare and fire, and an expired one also passes difference and increment through the
// shared adder; a flush state then presents the last item.
// One item at a time: a poll holds the input until the flush has presented its last item,
// and longer while results back up. Reset clears all slots to inactive.
// top level of the timer bank: sequencer, slot flags, result staging
// depends on ptb_pkg, ptb_alu, ptb_store, periodic_timer_bank_defines.svh
`timescale 1ns / 1ps
`include "periodic_timer_bank_defines.svh"

module periodic_timer_bank #(
   parameter int SLOT_COUNT = ptb_pkg::SLOT_COUNT_DEF,
   parameter int TIME_BITS  = ptb_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // slot_id[3:0], period[35:4], repeat_mode[36], run_now[37], auto_delete[38],
   // now_time[70:39], zero pad[71]
   input  logic [ptb_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [ptb_pkg::OP_W-1:0]       req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // fired_slot[3:0], zero pad[7:4]
   output logic [ptb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // fired[0]
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = ptb_pkg::RPT_CNT_W;

   // request fields
   logic [ptb_pkg::ID_W-1:0]      f_slot_id;
   logic [ptb_pkg::FIELD_T_W-1:0] f_period;
   logic                          f_repeat;
   logic                          f_run_now;
   logic                          f_auto_delete;
   logic [ptb_pkg::FIELD_T_W-1:0] f_now;
   ptb_pkg::op_type               f_op;

   assign f_slot_id     = req_tdata[3:0];
   assign f_period      = req_tdata[35:4];
   assign f_repeat      = req_tdata[36];
   assign f_run_now     = req_tdata[37];
   assign f_auto_delete = req_tdata[38];
   assign f_now         = req_tdata[70:39];
   assign f_op          = ptb_pkg::op_type'(req_tuser);

   // state
   ptb_pkg::state_type     state_ff, state_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [SLOT_COUNT-1:0]  active_ff, active_in;
   logic [SLOT_COUNT-1:0]  repeat_ff, repeat_in;
   logic [SLOT_COUNT-1:0]  run_now_ff, run_now_in;
   logic [SLOT_COUNT-1:0]  auto_del_ff, auto_del_in;
   logic [SLOT_COUNT-1:0]  called_ff, called_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [TIME_BITS-1:0]   e0_ff, e0_in;
   logic [TIME_BITS-1:0]   p_ff, p_in;
   logic [TIME_BITS-1:0]   np_ff, np_in;
   logic [TIME_BITS-1:0]   e1_ff, e1_in;
   logic [TIME_BITS-1:0]   diff_ff, diff_in;
   logic                   once_ff, once_in;
   logic                   hit_ff, hit_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [SW-1:0]          pend_slot_ff, pend_slot_in;
   logic [CW-1:0]          rpt_cnt_ff, rpt_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ptb_pkg::ID_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                   rsp_fired_ff, rsp_fired_in;
   logic                   rsp_last_ff, rsp_last_in;

   // shared adder and store wiring
   ptb_pkg::alu_op_type    alu_op;
   logic [TIME_BITS-1:0]   alu_a, alu_b, alu_y;
   ptb_pkg::store_we_type  st_we;
   logic [SW-1:0]          st_wr_addr;
   logic [TIME_BITS-1:0]   st_wr_expiry;
   logic [TIME_BITS-1:0]   rd_period, rd_expiry;

   logic                   out_free;
   logic                   id_ok;
   logic [SW-1:0]          id_idx;
   logic                   last_slot;
   logic [TIME_BITS-1:0]   e1_sel;
   logic                   report;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign id_ok     = 32'(f_slot_id) < 32'(SLOT_COUNT);
   assign id_idx    = SW'(f_slot_id);
   assign last_slot = slot_ff == SW'(SLOT_COUNT - 1);

   ptb_alu #(
      .TIME_BITS (TIME_BITS)
   ) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   ptb_store #(
      .SLOT_COUNT (SLOT_COUNT),
      .TIME_BITS  (TIME_BITS)
   ) u_store (
      .clock     (clock),
      .we        (st_we),
      .wr_addr   (st_wr_addr),
      .wr_period (TIME_BITS'(f_period)),
      .wr_expiry (st_wr_expiry),
      .rd_addr   (slot_ff),
      .rd_period (rd_period),
      .rd_expiry (rd_expiry)
   );

   // restart an expiry that is unset or lies beyond now + period
   assign e1_sel = ((np_ff < e0_ff) || (e0_ff == '0)) ? np_ff : e0_ff;

   // whether the fired slot is reported
   assign report = (repeat_ff[slot_ff] || !called_ff[slot_ff]) &&
                   (rpt_cnt_ff < CW'(ptb_pkg::MAX_RESULTS));

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      active_in     = active_ff;
      repeat_in     = repeat_ff;
      run_now_in    = run_now_ff;
      auto_del_in   = auto_del_ff;
      called_in     = called_ff;
      now_in        = now_ff;
      e0_in         = e0_ff;
      p_in          = p_ff;
      np_in         = np_ff;
      e1_in         = e1_ff;
      diff_in       = diff_ff;
      once_in       = once_ff;
      hit_in        = hit_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      rpt_cnt_in    = rpt_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_last_in   = rsp_last_ff;
      req_tready    = 1'b0;
      alu_op        = ptb_pkg::ALU_ADD;
      alu_a         = now_ff;
      alu_b         = rd_period;
      st_we         = '0;
      st_wr_addr    = slot_ff;
      st_wr_expiry  = e1_sel;

      case (state_ff)
         ptb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            st_wr_addr = id_idx;
            st_wr_expiry = '0;
            if (req_tvalid) begin
               case (f_op)
                  ptb_pkg::OP_ARM: begin
                     if (id_ok) begin
                        st_we.period_we     = 1'b1;
                        st_we.expiry_we     = 1'b1;
                        active_in[id_idx]   = 1'b1;
                        repeat_in[id_idx]   = f_repeat;
                        run_now_in[id_idx]  = f_run_now;
                        auto_del_in[id_idx] = f_auto_delete;
                        called_in[id_idx]   = 1'b0;
                     end
                  end
                  ptb_pkg::OP_FREE: begin
                     if (id_ok) begin
                        active_in[id_idx] = 1'b0;
                     end
                  end
                  ptb_pkg::OP_POLL: begin
                     now_in        = TIME_BITS'(f_now);
                     slot_in       = '0;
                     pend_valid_in = 1'b0;
                     rpt_cnt_in    = '0;
                     state_in      = ptb_pkg::ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptb_pkg::ST_READ: begin
            // store read of this slot is in flight
            if (active_ff[slot_ff]) begin
               state_in = ptb_pkg::ST_SUM;
            end else if (last_slot) begin
               state_in = ptb_pkg::ST_FLUSH;
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end
         ptb_pkg::ST_SUM: begin
            // now + period
            e0_in    = rd_expiry;
            p_in     = rd_period;
            np_in    = alu_y;
            once_in  = (rd_expiry == '0) && run_now_ff[slot_ff] && !called_ff[slot_ff];
            state_in = ptb_pkg::ST_CMP;
         end
         ptb_pkg::ST_CMP: begin
            e1_in  = e1_sel;
            hit_in = !(e1_sel > now_ff);
            if (e1_sel > now_ff) begin
               st_we.expiry_we = 1'b1;
               state_in        = ptb_pkg::ST_FIRE;
            end else begin
               state_in = ptb_pkg::ST_DIFF;
            end
         end
         ptb_pkg::ST_DIFF: begin
            // elapsed time past expiry
            alu_op   = ptb_pkg::ALU_SUB;
            alu_a    = now_ff;
            alu_b    = e1_ff;
            diff_in  = alu_y;
            state_in = ptb_pkg::ST_INC;
         end
         ptb_pkg::ST_INC: begin
            // catch up to now + period or step by one period
            alu_op          = ptb_pkg::ALU_ADD;
            alu_a           = e1_ff;
            alu_b           = p_ff;
            st_we.expiry_we = 1'b1;
            st_wr_expiry    = (diff_ff > p_ff) ? np_ff : alu_y;
            state_in        = ptb_pkg::ST_FIRE;
         end
         ptb_pkg::ST_FIRE: begin
            if (!(once_ff || hit_ff)) begin
               state_in = last_slot ? ptb_pkg::ST_FLUSH : ptb_pkg::ST_READ;
               slot_in  = last_slot ? slot_ff : slot_ff + SW'(1);
            end else if (!(report && pend_valid_ff && !out_free)) begin
               if (report) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = ptb_pkg::ID_W'(pend_slot_ff);
                     rsp_fired_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = slot_ff;
                  rpt_cnt_in    = rpt_cnt_ff + CW'(1);
               end
               called_in[slot_ff] = 1'b1;
               if (!repeat_ff[slot_ff] && auto_del_ff[slot_ff]) begin
                  active_in[slot_ff] = 1'b0;
               end
               state_in = last_slot ? ptb_pkg::ST_FLUSH : ptb_pkg::ST_READ;
               slot_in  = last_slot ? slot_ff : slot_ff + SW'(1);
            end
         end
         ptb_pkg::ST_FLUSH: begin
            // final item of the poll, or the empty result
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = pend_valid_ff ? ptb_pkg::ID_W'(pend_slot_ff) : '0;
               rsp_fired_in  = pend_valid_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ptb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptb_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptb_pkg::ST_IDLE;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rpt_cnt_ff    <= '0;
         slot_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rpt_cnt_ff    <= rpt_cnt_in;
         slot_ff       <= slot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      repeat_ff    <= repeat_in;
      run_now_ff   <= run_now_in;
      auto_del_ff  <= auto_del_in;
      called_ff    <= called_in;
      now_ff       <= now_in;
      e0_ff        <= e0_in;
      p_ff         <= p_in;
      np_ff        <= np_in;
      e1_ff        <= e1_in;
      diff_ff      <= diff_in;
      once_ff      <= once_in;
      hit_ff       <= hit_in;
      pend_slot_ff <= pend_slot_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ptb_pkg::RSP_DATA_W'(rsp_slot_ff);
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `PTB_ASSERT_RST(a_ready_no_pend, clock, reset,
      req_tready |-> !pend_valid_ff, "ready with a result still held back")
   `PTB_ASSERT_RST(a_flush_ends, clock, reset,
      (state_ff == ptb_pkg::ST_FLUSH) && out_free |=>
         (state_ff == ptb_pkg::ST_IDLE) && rsp_valid_ff && rsp_last_ff,
      "poll flush did not close with a last item")
   `PTB_ASSERT_RST(a_cnt_bound, clock, reset,
      rpt_cnt_ff <= CW'(ptb_pkg::MAX_RESULTS), "result count above limit")
   `PTB_ASSERT_RST(a_empty_is_last, clock, reset,
      rsp_valid_ff && !rsp_fired_ff |-> rsp_last_ff, "empty result not marked last")
   `PTB_ASSERT_ALWAYS(a_reset_quiet, clock,
      reset |=> (state_ff == ptb_pkg::ST_IDLE) && !rsp_valid_ff && !pend_valid_ff,
      "reset did not return the sequencer to idle")

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for periodic_timer_bank: arm, free, no-op and poll items with
// random handshake gaps, every result checked against an in-bench timer predictor
// depends on ptb_pkg and the periodic_timer_bank rtl
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS        = ptb_pkg::SLOT_COUNT_DEF;
   localparam int ID_BITS      = ptb_pkg::ID_W;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 150;

   // one expected poll result
   typedef struct packed {
      logic [ID_BITS-1:0] slot;
      logic               fired;
      logic               last_flag;
   } fire_record_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic [ptb_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ptb_pkg::OP_W-1:0]       req_tuser = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ptb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;

   // predicted slot state
   logic        slot_on[SLOTS];
   logic [31:0] slot_per[SLOTS];
   logic [31:0] slot_exp[SLOTS];
   logic        slot_repeat[SLOTS];
   logic        slot_run_now[SLOTS];
   logic        slot_auto_del[SLOTS];
   logic        slot_called[SLOTS];

   fire_record_type pending_fires[$];

   int    cycle_count    = 0;
   int    mismatch_count = 0;
   int    items_sent     = 0;
   int    polls_sent     = 0;
   int    results_seen   = 0;
   int    fires_seen     = 0;
   int    stall_left     = 0;
   bit    req_gaps_on    = 1'b1;
   bit    rsp_stalls_on  = 1'b1;
   logic [31:0] tick     = 32'd0;

   periodic_timer_bank i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 12 ns clock
   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap(input bit enable);
      int r;
      r = $urandom_range(0, 99);
      if (!enable || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // result side backpressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
         stall_left = pick_gap(1'b1);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each accepted result with the oldest predicted one
   always @(posedge clock) begin
      fire_record_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser)
            fires_seen++;
         if (pending_fires.size() == 0) begin
            $error("unexpected result: fired_slot %0d fired %0d last %0d",
                   rsp_tdata[ID_BITS-1:0], rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_fires.pop_front();
            if (rsp_tdata[ID_BITS-1:0] !== want.slot) begin
               $error("fired_slot: expected %0d, got %0d", want.slot,
                      rsp_tdata[ID_BITS-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.fired) begin
               $error("fired: expected %0d, got %0d", want.fired, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last_flag) begin
               $error("last: expected %0d, got %0d", want.last_flag, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // walk the active slots for one poll and queue what should fire
   function automatic void predict_poll(input logic [31:0] now_t);
      logic [31:0] sum;
      logic [31:0] due;
      logic        once;
      logic        hit;
      int          fires;
      int          s;
      fire_record_type rec;
      fires = 0;
      for (s = 0; s < SLOTS; s++) begin
         if (!slot_on[s])
            continue;
         once = (slot_exp[s] == 32'd0) && slot_run_now[s] && !slot_called[s];
         sum  = now_t + slot_per[s];
         due  = slot_exp[s];
         // wrapped schedule restarts, unstarted slot arms on this poll
         if (sum < due)
            due = 32'd0;
         if (due == 32'd0)
            due = sum;
         if (due > now_t) begin
            hit = 1'b0;
         end else begin
            hit = 1'b1;
            // far behind: reschedule from now, else step one period
            due = ((now_t - due) > slot_per[s]) ? sum : due + slot_per[s];
         end
         slot_exp[s] = due;
         if (!once && !hit)
            continue;
         if ((slot_repeat[s] || !slot_called[s]) && fires < ptb_pkg::MAX_RESULTS) begin
            rec.slot      = ID_BITS'(s);
            rec.fired     = 1'b1;
            rec.last_flag = 1'b0;
            pending_fires.push_back(rec);
            fires++;
         end
         slot_called[s] = 1'b1;
         if (!slot_repeat[s] && slot_auto_del[s])
            slot_on[s] = 1'b0;
      end
      if (fires == 0) begin
         rec.slot      = '0;
         rec.fired     = 1'b0;
         rec.last_flag = 1'b1;
         pending_fires.push_back(rec);
      end else begin
         pending_fires[pending_fires.size() - 1].last_flag = 1'b1;
      end
   endfunction

   // drive one item, wait for it to be taken, update the prediction
   task automatic send_item(input ptb_pkg::op_type op, input logic [ID_BITS-1:0] id,
                            input logic [31:0] per, input logic rep, input logic rn,
                            input logic ad, input logic [31:0] now_t);
      int gap;
      req_tuser  <= op;
      req_tdata  <= {1'b0, now_t, ad, rn, rep, per, id};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      case (op)
         ptb_pkg::OP_ARM: begin
            slot_on[id]       = 1'b1;
            slot_per[id]      = per;
            slot_exp[id]      = 32'd0;
            slot_repeat[id]   = rep;
            slot_run_now[id]  = rn;
            slot_auto_del[id] = ad;
            slot_called[id]   = 1'b0;
         end
         ptb_pkg::OP_FREE:
            slot_on[id] = 1'b0;
         ptb_pkg::OP_POLL: begin
            polls_sent++;
            predict_poll(now_t);
         end
         default: ;
      endcase
      gap = pick_gap(req_gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic arm(input logic [ID_BITS-1:0] id, input logic [31:0] per,
                      input logic rep, input logic rn, input logic ad);
      send_item(ptb_pkg::OP_ARM, id, per, rep, rn, ad, $urandom);
   endtask

   task automatic free(input logic [ID_BITS-1:0] id);
      send_item(ptb_pkg::OP_FREE, id, $urandom, 1'($urandom), 1'($urandom),
                1'($urandom), $urandom);
   endtask

   task automatic poll(input logic [31:0] now_t);
      send_item(ptb_pkg::OP_POLL, ID_BITS'($urandom), $urandom, 1'($urandom),
                1'($urandom), 1'($urandom), now_t);
   endtask

   // hold the sender until every predicted result has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_fires.size() != 0);
   endtask

   // empty polls, reserved op, one-shot, auto-delete, catch-up and time wrap
   task automatic test_directed();
      poll(32'd0);
      poll(32'hFFFF_FFFF);
      send_item(ptb_pkg::OP_NONE, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      free(4'd5);
      arm(4'd0, 32'd10, 1'b1, 1'b1, 1'b0);
      poll(32'd100);
      poll(32'd105);
      poll(32'd110);
      poll(32'd5000);
      arm(4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
      arm(4'd3, 32'd0, 1'b0, 1'b1, 1'b1);
      arm(4'd4, 32'd0, 1'b0, 1'b0, 1'b0);
      poll(32'd5001);
      poll(32'd6000);
      poll(32'd6001);
      // reload an active slot
      arm(4'd0, 32'd20, 1'b1, 1'b0, 1'b0);
      poll(32'hFFFF_FFF0);
      poll(32'hFFFF_FFFF);
      poll(32'd5);
      free(4'd0);
      free(4'd15);
      free(4'd4);
      poll(32'd10);
   endtask

   // every slot fires in the same poll, no idling on either side
   task automatic test_all_slots_fire();
      int s;
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      wait_drained();
      for (s = 0; s < SLOTS; s++)
         arm(ID_BITS'(s), 32'(s % 3), 1'b1, 1'b1, 1'b0);
      poll(32'd20000);
      poll(32'd20001);
      poll(32'd20003);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // random mix, mostly arms and polls with time moving forward
   task automatic test_random_traffic(input int count);
      int i;
      int r;
      int r2;
      logic [31:0] per;
      tick = 32'd30000;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            req_gaps_on   = (i / 40) % 3 != 1;
            rsp_stalls_on = (i / 40) % 3 != 2;
         end
         if (i == count / 2)
            wait_drained();
         r  = $urandom_range(0, 99);
         r2 = $urandom_range(0, 99);
         if (r < 28) begin
            if (r2 < 70)
               per = $urandom_range(0, 40);
            else if (r2 < 90)
               per = $urandom_range(41, 2000);
            else
               per = $urandom;
            arm(ID_BITS'($urandom_range(0, SLOTS - 1)), per, 1'($urandom),
                1'($urandom), 1'($urandom));
         end else if (r < 38) begin
            free(ID_BITS'($urandom_range(0, SLOTS - 1)));
         end else if (r < 42) begin
            send_item(ptb_pkg::OP_NONE, ID_BITS'($urandom), $urandom, 1'($urandom),
                      1'($urandom), 1'($urandom), $urandom);
         end else begin
            if (r2 < 80)
               tick = tick + $urandom_range(0, 25);
            else if (r2 < 92)
               tick = tick + $urandom_range(26, 5000);
            else if (r2 < 97)
               tick = $urandom;
            else
               tick = 32'hFFFF_FFFF - $urandom_range(0, 30);
            poll(tick);
         end
      end
   endtask

   initial begin
      int s;
      for (s = 0; s < SLOTS; s++) begin
         slot_on[s]       = 1'b0;
         slot_per[s]      = '0;
         slot_exp[s]      = '0;
         slot_repeat[s]   = 1'b0;
         slot_run_now[s]  = 1'b0;
         slot_auto_del[s] = 1'b0;
         slot_called[s]   = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_all_slots_fire();
      test_random_traffic(120);

      // drain, then give the block time to show any stray result
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_fires.size() != 0) begin
         $error("%0d predicted results never arrived", pending_fires.size());
         mismatch_count++;
      end

      $display("sent %0d items (%0d polls), checked %0d results of which %0d fired a slot",
               items_sent, polls_sent, results_seen, fires_seen);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== periodic_timer_bank.f =====
+incdir+hdl
hdl/ptb_pkg.sv
hdl/ptb_alu.sv
hdl/ptb_store.sv
hdl/periodic_timer_bank.sv
sim/testbench.sv
